>>> hw/rtl/tssr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tssr_pkg;

    // Storage geometry
    localparam int BANK_BYTES  = 8192;
    localparam int TILE_BYTES  = 2 * BANK_BYTES;
    localparam int TILE_AW     = 14;
    localparam int OBJ_BYTES   = 160;
    localparam int OBJ_AW      = 8;
    localparam int PAL_SLOTS   = 76;
    localparam int PAL_AW      = 7;
    localparam int SCREEN_W    = 160;
    localparam int LB_AW       = 8;
    localparam int LB_W        = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Map and tile data bases (offsets inside one bank)
    localparam logic [12:0] MAP_BASE_LO   = 13'h1800;
    localparam logic [12:0] MAP_BASE_HI   = 13'h1C00;
    localparam logic [12:0] SIGNED_BASE   = 13'h0800;
    localparam logic [7:0]  SIGNED_BIAS   = 8'h80;

    // Palette slot bases
    localparam logic [PAL_AW-1:0] PAL_CGB_OBJ     = 7'd32;
    localparam logic [PAL_AW-1:0] PAL_CLASSIC_BG  = 7'd64;
    localparam logic [PAL_AW-1:0] PAL_CLASSIC_OBJ = 7'd68;

    localparam logic [15:0] BLANK_COLOUR = 16'hFFFF;
    localparam logic [7:0]  WX_LIMIT     = 8'd166;
    localparam logic [8:0]  SX_LIMIT     = 9'd168;
    localparam logic [5:0]  LAST_GROUP   = 6'd39;
    localparam logic [7:0]  LAST_X       = 8'd159;

    // Configuration register indexes
    localparam logic [2:0] CFG_LCD_CONTROL = 3'd0;
    localparam logic [2:0] CFG_SCROLL_Y    = 3'd1;
    localparam logic [2:0] CFG_SCROLL_X    = 3'd2;
    localparam logic [2:0] CFG_WINDOW_Y    = 3'd3;
    localparam logic [2:0] CFG_WINDOW_X    = 3'd4;
    localparam logic [2:0] CFG_FRAME_SKIP  = 3'd5;
    localparam logic [2:0] CFG_COLOUR_MODE = 3'd6;

    typedef enum logic [1:0] {
        CMD_TILE_WR = 2'd0,
        CMD_OBJ_WR  = 2'd1,
        CMD_PAL_WR  = 2'd2,
        CMD_RENDER  = 2'd3
    } cmd_t;

    // One classified word on its way from the front to the back
    typedef struct packed {
        cmd_t        cmd;
        logic [13:0] addr;
        logic [15:0] data;
        logic [7:0]  line;
    } item_t;

    // Two-bit colour index of one tile column
    function automatic logic [1:0] pixel_index(input logic [7:0] lo, input logic [7:0] hi,
                                               input logic [2:0] col, input logic flip);
        logic [2:0] b;
        b = flip ? col : 3'd7 - col;
        return {hi[b], lo[b]};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tssr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tssr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/tssr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tssr_front
    import tssr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // addr[13:0], data[29:14], line[37:30]
    input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic             q_valid,
    output item_t            q_item,
    input  wire logic        q_pop
);

    item_t                q_reg [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    item_t                in_item;
    logic                 keep, push;

    // Unpack and classify the incoming word
    always_comb
    begin
        in_item.cmd  = cmd_t'(s_axis_tuser);
        in_item.addr = s_axis_tdata[13:0];
        in_item.data = s_axis_tdata[29:14];
        in_item.line = s_axis_tdata[37:30];
        case (in_item.cmd)
            CMD_OBJ_WR: keep = (in_item.addr < 14'(OBJ_BYTES));
            CMD_PAL_WR: keep = (in_item.addr < 14'(PAL_SLOTS));
            default:    keep = 1'b1;
        endcase
    end

    assign s_axis_tready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign q_valid       = (count_reg != '0);
    assign q_item        = q_reg[rd_ptr_reg];

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tssr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tssr_back
    import tssr_pkg::*;
#(
    parameter int OBJECT_COUNT     = 40,
    parameter int OBJECTS_PER_LINE = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire item_t       q_item,
    output logic             q_pop,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    localparam int OBJ_IW = (OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1;
    localparam int SLOT_W = $clog2(OBJECTS_PER_LINE + 1);
    localparam int NSLOT  = 1 << SLOT_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_FILL, ST_BG_PIX, ST_F_ATTR, ST_F_LOC, ST_F_LO, ST_F_HI,
        ST_PX_PAL, ST_PX_WR, ST_OB_BEGIN, ST_SC_Y, ST_SC_X, ST_SC_EV, ST_DR_BEGIN,
        ST_DR_SY, ST_DR_SX, ST_DR_ST, ST_DR_SA, ST_DR_CAP, ST_DR_LO, ST_DR_HI,
        ST_DR_GH, ST_DR_PX, ST_DR_PW, ST_EM_RD, ST_EM_PUSH
    } state_t;

    // Configuration registers
    logic [7:0] lcdc_reg, scy_reg, scx_reg, wy_reg, wx_reg, fsp_reg;
    logic       cgb_reg;

    state_t state_reg, state_next;
    logic [7:0] fsc_reg, fsc_next, wrc_reg, wrc_next;
    logic [7:0] line_reg, line_next, x_reg, x_next, wrow_reg, wrow_next;
    logic       win_line_reg, win_line_next, prev_win_reg, prev_win_next;
    logic       first_reg, first_next;
    logic [7:0] tile_reg, tile_next, attr_reg, attr_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [TILE_AW-1:0] addr_reg, addr_next;
    logic [OBJ_IW-1:0]  obj_i_reg, obj_i_next;
    logic [SLOT_W-1:0]  cnt_reg, cnt_next, k_reg, k_next;
    logic [7:0]  slot_x_reg [0:NSLOT-1];
    logic [7:0]  slot_x_next [0:NSLOT-1];
    logic [OBJ_IW-1:0] slot_i_reg [0:NSLOT-1];
    logic [OBJ_IW-1:0] slot_i_next [0:NSLOT-1];
    logic [7:0] sy_reg, sy_next, sx_reg, sx_next, st_reg, st_next, sa_reg, sa_next;
    logic [2:0] c_reg, c_next, j_reg, j_next;
    logic [5:0] grp_reg, grp_next;
    logic [15:0] px_reg [0:3];
    logic [15:0] px_next [0:3];
    logic        out_valid_reg, out_valid_next, out_last_reg, out_last_next;
    logic [7:0]  out_line_reg, out_line_next;
    logic [5:0]  out_grp_reg, out_grp_next;
    logic [15:0] out_px_reg [0:3];
    logic [15:0] out_px_next [0:3];

    // Memory ports
    logic               tile_we, obj_we, pal_we, lb_we;
    logic [TILE_AW-1:0] tile_raddr;
    logic [7:0]         tile_rdata;
    logic [OBJ_AW-1:0]  obj_raddr;
    logic [7:0]         obj_rdata;
    logic [PAL_AW-1:0]  pal_raddr;
    logic [15:0]        pal_rdata;
    logic [LB_AW-1:0]   lb_waddr, lb_raddr;
    logic [LB_W-1:0]    lb_wdata, lb_rdata;

    tssr_ram #(.WIDTH(8), .DEPTH(TILE_BYTES)) u_tile_ram (
        .clk(clk), .we(tile_we), .waddr(q_item.addr), .wdata(q_item.data[7:0]),
        .raddr(tile_raddr), .rdata(tile_rdata)
    );

    tssr_ram #(.WIDTH(8), .DEPTH(OBJ_BYTES)) u_obj_ram (
        .clk(clk), .we(obj_we), .waddr(q_item.addr[OBJ_AW-1:0]), .wdata(q_item.data[7:0]),
        .raddr(obj_raddr), .rdata(obj_rdata)
    );

    tssr_ram #(.WIDTH(16), .DEPTH(PAL_SLOTS)) u_pal_ram (
        .clk(clk), .we(pal_we), .waddr(q_item.addr[PAL_AW-1:0]), .wdata(q_item.data),
        .raddr(pal_raddr), .rdata(pal_rdata)
    );

    tssr_ram #(.WIDTH(LB_W), .DEPTH(SCREEN_W)) u_line_ram (
        .clk(clk), .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
        .raddr(lb_raddr), .rdata(lb_rdata)
    );

    // Configuration writes, taken at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcdc_reg <= 8'd145;
            scy_reg  <= '0;
            scx_reg  <= '0;
            wy_reg   <= '0;
            wx_reg   <= '0;
            fsp_reg  <= 8'd1;
            cgb_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LCD_CONTROL: lcdc_reg <= cfg_data;
                CFG_SCROLL_Y:    scy_reg  <= cfg_data;
                CFG_SCROLL_X:    scx_reg  <= cfg_data;
                CFG_WINDOW_Y:    wy_reg   <= cfg_data;
                CFG_WINDOW_X:    wx_reg   <= cfg_data;
                CFG_FRAME_SKIP:  fsp_reg  <= cfg_data;
                CFG_COLOUR_MODE: cgb_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Background / window source for the current column
    logic        sel_win;
    logic [7:0]  row8, col8;
    logic [12:0] map_addr;
    logic [2:0]  frow;
    logic [12:0] tdata_off;
    logic [1:0]  bg_idx;
    logic [PAL_AW-1:0] bg_pal;

    always_comb
    begin
        sel_win  = win_line_reg && (({1'b0, x_reg} + 9'd7) >= {1'b0, wx_reg});
        row8     = sel_win ? wrow_reg : 8'(scy_reg + line_reg);
        col8     = sel_win ? 8'(x_reg + 8'd7 - wx_reg) : 8'(scx_reg + x_reg);
        map_addr = ((sel_win ? lcdc_reg[6] : lcdc_reg[3]) ? MAP_BASE_HI : MAP_BASE_LO)
                   + {3'b000, row8[7:3], col8[7:3]};
        // F_LOC sees the attribute byte on the read port
        frow      = row8[2:0] ^ {3{cgb_reg && tile_rdata[6]}};
        tdata_off = (lcdc_reg[4] ? 13'h0000 : SIGNED_BASE) + {1'b0, tile_reg, 4'b0000}
                    + {9'b0, frow, 1'b0};
        bg_idx    = pixel_index(lo_reg, hi_reg, col8[2:0], attr_reg[5]);
        bg_pal    = cgb_reg ? {2'b00, attr_reg[2:0], bg_idx} : PAL_CLASSIC_BG + 7'(bg_idx);
    end

    // Object scan and draw helpers
    logic [8:0]  ln16, height9, x9;
    logic [7:0]  er0, er;
    logic        reject, onscr;
    logic [1:0]  ob_idx;
    logic [PAL_AW-1:0] ob_pal;
    logic [NSLOT-1:0]  le;
    logic [7:0]  ins_x [0:NSLOT-1];
    logic [OBJ_IW-1:0] ins_i [0:NSLOT-1];
    logic [OBJ_IW-1:0] cur_obj;

    always_comb
    begin
        ln16    = {1'b0, line_reg} + 9'd16;
        height9 = lcdc_reg[2] ? 9'd16 : 9'd8;
        reject  = (sy_reg == 8'd0) || (obj_rdata == 8'd0) || ({1'b0, obj_rdata} > SX_LIMIT)
                  || ({1'b0, sy_reg} > ln16) || (({1'b0, sy_reg} + height9) <= ln16);
        er0     = 8'(line_reg + 8'd16 - sy_reg);
        er      = sa_reg[6] ? 8'(height9[7:0] - er0 - 8'd1) : er0;
        x9      = {1'b0, sx_reg} + {6'b0, c_reg};
        onscr   = (x9 >= 9'd8) && (x9 < SX_LIMIT);
        ob_idx  = pixel_index(lo_reg, hi_reg, c_reg, sa_reg[5]);
        ob_pal  = cgb_reg ? PAL_CGB_OBJ + {2'b00, sa_reg[2:0], ob_idx}
                          : PAL_CLASSIC_OBJ + (sa_reg[4] ? 7'd4 : 7'd0) + 7'(ob_idx);
        cur_obj = slot_i_reg[k_reg];
        // Sorted insert (classic mode): leftmost first, equal x keeps table order
        for (int j = 0; j < NSLOT; j++)
        begin
            le[j] = (SLOT_W'(j) < cnt_reg) && (cgb_reg || (slot_x_reg[j] <= obj_rdata));
        end
        for (int j = 0; j < NSLOT; j++)
        begin
            ins_x[j] = slot_x_reg[j];
            ins_i[j] = slot_i_reg[j];
            if (j < OBJECTS_PER_LINE && !le[j])
            begin
                if (j == 0 || le[(j == 0) ? 0 : j-1])
                begin
                    ins_x[j] = obj_rdata;
                    ins_i[j] = obj_i_reg;
                end
                else
                begin
                    ins_x[j] = slot_x_reg[(j == 0) ? 0 : j-1];
                    ins_i[j] = slot_i_reg[(j == 0) ? 0 : j-1];
                end
            end
        end
    end

    // Sequencer: writes, line build, object pass, group output
    always_comb
    begin
        state_next     = state_reg;
        fsc_next       = fsc_reg;
        wrc_next       = wrc_reg;
        line_next      = line_reg;
        x_next         = x_reg;
        wrow_next      = wrow_reg;
        win_line_next  = win_line_reg;
        prev_win_next  = prev_win_reg;
        first_next     = first_reg;
        tile_next      = tile_reg;
        attr_next      = attr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        addr_next      = addr_reg;
        obj_i_next     = obj_i_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        sy_next        = sy_reg;
        sx_next        = sx_reg;
        st_next        = st_reg;
        sa_next        = sa_reg;
        c_next         = c_reg;
        j_next         = j_reg;
        grp_next       = grp_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_last_next  = out_last_reg;
        out_line_next  = out_line_reg;
        out_grp_next   = out_grp_reg;
        for (int j = 0; j < NSLOT; j++)
        begin
            slot_x_next[j] = slot_x_reg[j];
            slot_i_next[j] = slot_i_reg[j];
        end
        for (int p = 0; p < 4; p++)
        begin
            px_next[p]     = px_reg[p];
            out_px_next[p] = out_px_reg[p];
        end

        q_pop      = 1'b0;
        tile_we    = 1'b0;
        obj_we     = 1'b0;
        pal_we     = 1'b0;
        lb_we      = 1'b0;
        tile_raddr = '0;
        obj_raddr  = '0;
        pal_raddr  = bg_pal;
        lb_waddr   = x_reg;
        lb_wdata   = {attr_reg, pal_rdata};
        lb_raddr   = {grp_reg, j_reg[1:0]};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_item.cmd)
                        CMD_TILE_WR: tile_we = 1'b1;
                        CMD_OBJ_WR:  obj_we  = 1'b1;
                        CMD_PAL_WR:  pal_we  = 1'b1;
                        default:
                        begin
                            line_next  = q_item.line;
                            state_next = ST_START;
                        end
                    endcase
                end
            end

            ST_START:
            begin
                // Line zero opens a frame: advance the skip count, restart window rows
                if (line_reg == 8'd0)
                begin
                    fsc_next = (8'(fsc_reg + 8'd1) == fsp_reg) ? 8'd0 : 8'(fsc_reg + 8'd1);
                end
                wrow_next     = (line_reg == 8'd0) ? 8'd0 : wrc_reg;
                wrc_next      = wrow_next;
                x_next        = '0;
                first_next    = 1'b1;
                win_line_next = 1'b0;
                if (fsc_next != 8'd0)
                begin
                    state_next = ST_IDLE;
                end
                else if (cgb_reg || lcdc_reg[0])
                begin
                    win_line_next = lcdc_reg[5] && (line_reg >= wy_reg) && (wx_reg <= WX_LIMIT);
                    if (win_line_next)
                    begin
                        wrc_next = 8'(wrow_next + 8'd1);
                    end
                    state_next = ST_BG_PIX;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end

            ST_FILL:
            begin
                lb_we    = 1'b1;
                lb_wdata = {8'h00, BLANK_COLOUR};
                x_next   = 8'(x_reg + 8'd1);
                if (x_reg == LAST_X)
                begin
                    state_next = ST_OB_BEGIN;
                end
            end

            ST_BG_PIX:
            begin
                if (first_reg || (sel_win != prev_win_reg) || (col8[2:0] == 3'd0))
                begin
                    tile_raddr = {1'b0, map_addr};
                    state_next = ST_F_ATTR;
                end
                else
                begin
                    state_next = ST_PX_WR;
                end
            end

            ST_F_ATTR:
            begin
                tile_next  = 8'(tile_rdata + (lcdc_reg[4] ? 8'h00 : SIGNED_BIAS));
                tile_raddr = {1'b1, map_addr};
                state_next = ST_F_LOC;
            end

            ST_F_LOC:
            begin
                attr_next  = cgb_reg ? tile_rdata : 8'h00;
                addr_next  = {cgb_reg && tile_rdata[3], tdata_off};
                tile_raddr = addr_next;
                state_next = ST_F_LO;
            end

            ST_F_LO:
            begin
                lo_next    = tile_rdata;
                tile_raddr = TILE_AW'(addr_reg + 1'b1);
                state_next = ST_F_HI;
            end

            ST_F_HI:
            begin
                hi_next    = tile_rdata;
                state_next = ST_PX_PAL;
            end

            ST_PX_PAL:
            begin
                state_next = ST_PX_WR;
            end

            ST_PX_WR:
            begin
                lb_we         = 1'b1;
                prev_win_next = sel_win;
                first_next    = 1'b0;
                x_next        = 8'(x_reg + 8'd1);
                state_next    = (x_reg == LAST_X) ? ST_OB_BEGIN : ST_BG_PIX;
            end

            ST_OB_BEGIN:
            begin
                obj_i_next = '0;
                cnt_next   = '0;
                grp_next   = '0;
                j_next     = '0;
                state_next = lcdc_reg[1] ? ST_SC_Y : ST_EM_RD;
            end

            ST_SC_Y:
            begin
                obj_raddr  = OBJ_AW'({obj_i_reg, 2'b00});
                state_next = ST_SC_X;
            end

            ST_SC_X:
            begin
                obj_raddr  = OBJ_AW'({obj_i_reg, 2'b01});
                sy_next    = obj_rdata;
                state_next = ST_SC_EV;
            end

            ST_SC_EV:
            begin
                if (!reject)
                begin
                    for (int j = 0; j < NSLOT; j++)
                    begin
                        slot_x_next[j] = ins_x[j];
                        slot_i_next[j] = ins_i[j];
                    end
                    if (cnt_reg != SLOT_W'(OBJECTS_PER_LINE))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                obj_i_next = obj_i_reg + 1'b1;
                state_next = (obj_i_reg == OBJ_IW'(OBJECT_COUNT - 1)) ? ST_DR_BEGIN : ST_SC_Y;
            end

            ST_DR_BEGIN:
            begin
                k_next     = cnt_reg - 1'b1;
                state_next = (cnt_reg == '0) ? ST_EM_RD : ST_DR_SY;
            end

            ST_DR_SY:
            begin
                obj_raddr  = OBJ_AW'({cur_obj, 2'b00});
                state_next = ST_DR_SX;
            end

            ST_DR_SX:
            begin
                obj_raddr  = OBJ_AW'({cur_obj, 2'b01});
                sy_next    = obj_rdata;
                state_next = ST_DR_ST;
            end

            ST_DR_ST:
            begin
                obj_raddr  = OBJ_AW'({cur_obj, 2'b10});
                sx_next    = obj_rdata;
                state_next = ST_DR_SA;
            end

            ST_DR_SA:
            begin
                obj_raddr  = OBJ_AW'({cur_obj, 2'b11});
                st_next    = obj_rdata & (lcdc_reg[2] ? 8'hFE : 8'hFF);
                state_next = ST_DR_CAP;
            end

            ST_DR_CAP:
            begin
                sa_next    = obj_rdata;
                state_next = ST_DR_LO;
            end

            ST_DR_LO:
            begin
                addr_next  = TILE_AW'({st_reg, 4'b0000}) + TILE_AW'({er, 1'b0})
                             + ((cgb_reg && sa_reg[3]) ? TILE_AW'(BANK_BYTES) : '0);
                tile_raddr = addr_next;
                state_next = ST_DR_HI;
            end

            ST_DR_HI:
            begin
                lo_next    = tile_rdata;
                tile_raddr = TILE_AW'(addr_reg + 1'b1);
                state_next = ST_DR_GH;
            end

            ST_DR_GH:
            begin
                hi_next    = tile_rdata;
                c_next     = '0;
                state_next = ST_DR_PX;
            end

            ST_DR_PX:
            begin
                lb_raddr  = 8'(x9 - 9'd8);
                pal_raddr = ob_pal;
                if (onscr && ob_idx != 2'd0)
                begin
                    state_next = ST_DR_PW;
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                    if (c_reg == 3'd7)
                    begin
                        k_next     = k_reg - 1'b1;
                        state_next = (k_reg == '0) ? ST_EM_RD : ST_DR_SY;
                    end
                end
            end

            ST_DR_PW:
            begin
                // Background-priority rule against the pixel beneath
                lb_waddr = 8'(x9 - 9'd8);
                lb_wdata = {lb_rdata[23:16], pal_rdata};
                lb_we    = lb_rdata[0] || !(sa_reg[7] || lb_rdata[23]);
                c_next   = c_reg + 1'b1;
                if (c_reg == 3'd7)
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = (k_reg == '0) ? ST_EM_RD : ST_DR_SY;
                end
                else
                begin
                    state_next = ST_DR_PX;
                end
            end

            ST_EM_RD:
            begin
                if (j_reg != 3'd0)
                begin
                    px_next[2'(j_reg - 3'd1)] = lb_rdata[15:0];
                end
                j_next = j_reg + 3'd1;
                if (j_reg == 3'd4)
                begin
                    state_next = ST_EM_PUSH;
                end
            end

            ST_EM_PUSH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_line_next  = line_reg;
                    out_grp_next   = grp_reg;
                    out_last_next  = (grp_reg == LAST_GROUP);
                    for (int p = 0; p < 4; p++)
                    begin
                        out_px_next[p] = px_reg[p];
                    end
                    grp_next   = grp_reg + 6'd1;
                    j_next     = '0;
                    state_next = (grp_reg == LAST_GROUP) ? ST_IDLE : ST_EM_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fsc_reg       <= '0;
            wrc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fsc_reg       <= fsc_next;
            wrc_reg       <= wrc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        line_reg     <= line_next;
        x_reg        <= x_next;
        wrow_reg     <= wrow_next;
        win_line_reg <= win_line_next;
        prev_win_reg <= prev_win_next;
        first_reg    <= first_next;
        tile_reg     <= tile_next;
        attr_reg     <= attr_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        addr_reg     <= addr_next;
        obj_i_reg    <= obj_i_next;
        cnt_reg      <= cnt_next;
        k_reg        <= k_next;
        sy_reg       <= sy_next;
        sx_reg       <= sx_next;
        st_reg       <= st_next;
        sa_reg       <= sa_next;
        c_reg        <= c_next;
        j_reg        <= j_next;
        grp_reg      <= grp_next;
        out_last_reg <= out_last_next;
        out_line_reg <= out_line_next;
        out_grp_reg  <= out_grp_next;
        for (int j = 0; j < NSLOT; j++)
        begin
            slot_x_reg[j] <= slot_x_next[j];
            slot_i_reg[j] <= slot_i_next[j];
        end
        for (int p = 0; p < 4; p++)
        begin
            px_reg[p]     <= px_next[p];
            out_px_reg[p] <= out_px_next[p];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_px_reg[3], out_px_reg[2], out_px_reg[1],
                            out_px_reg[0], out_grp_reg, out_line_reg};

endmodule

`default_nettype wire

>>> hw/rtl/tile_sprite_scanline_renderer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: addr, data, line; tuser: cmd
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: line_number, group, pixels; tlast
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// The back end takes write words in its idle state. A render word builds the
// line with tile fetches, scans the object table, draws each selected object
// and sends four-pixel groups out; the single read port of each memory paces
// these steps. A four-deep queue lets input words arrive while a line renders.
// Reset clears control only; memories hold whatever was written. A stalled
// output holds the back end at its next group.

module tile_sprite_scanline_renderer_unit
    import tssr_pkg::*;
#(
    parameter int OBJECT_COUNT     = 40,
    parameter int OBJECTS_PER_LINE = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // addr[13:0], data[29:14], line[37:30]
    input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // line_number[7:0], group[13:8], pixel_a[29:14],
                                             // pixel_b[45:30], pixel_c[61:46], pixel_d[77:62]
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic  q_valid, q_pop;
    item_t q_item;

    tssr_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    tssr_back #(
        .OBJECT_COUNT(OBJECT_COUNT),
        .OBJECTS_PER_LINE(OBJECTS_PER_LINE)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tssr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int HOLD_CYCLES    = 3000;

    localparam int OBJECT_COUNT_TB      = 40;
    localparam int OBJECTS_PER_LINE_TB  = 10;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    tile_sprite_scanline_renderer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // One four-pixel group as the block should send it
    typedef struct {
        logic [7:0]  line_no;
        logic [5:0]  grp;
        logic [15:0] px [4];
        logic        last;
    } pixel_group_t;

    pixel_group_t pixel_groups_due[$];

    // Shadow of the block's stores, registers and counters
    logic [7:0]  vram_shadow [TILE_BYTES];
    logic [7:0]  oam_shadow [OBJ_BYTES];
    logic [15:0] pal_shadow [PAL_SLOTS];
    logic [7:0]  lcdc, scy, scx, wy, wx, skip_period;
    logic        colour_on;
    logic [7:0]  skip_count, win_row;
    logic [15:0] line_pix [SCREEN_W];
    logic [7:0]  line_prio [SCREEN_W];

    int  mismatches;
    int  stall_cycles;
    bit  tx_idle_en;
    bit  rx_idle_en;
    bit  rx_hold_req;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [1:0] col_index(logic [7:0] lo, logic [7:0] hi, int c, bit flip);
        int b;
        b = flip ? (c & 7) : 7 - (c & 7);
        return {hi[b], lo[b]};
    endfunction

    function automatic logic [7:0] vram_rd(int a);
        return vram_shadow[a & (TILE_BYTES - 1)];
    endfunction

    // Background or window pixel from a tile map
    function automatic void tile_dot(int map_base, int row, int col, int x);
        int map_addr, tile, attr, r, a;
        logic [1:0] idx;
        map_addr = map_base + ((row >> 3) & 31) * 32 + ((col >> 3) & 31);
        tile = (vram_rd(map_addr) + (lcdc[4] ? 0 : 'h80)) & 'hFF;
        attr = colour_on ? vram_rd(BANK_BYTES + map_addr) : 0;
        r = row & 7;
        if (attr & 'h40)
            r = 7 - r;
        a = (lcdc[4] ? 0 : 'h800) + tile * 16 + 2 * r + ((attr & 8) ? BANK_BYTES : 0);
        idx = col_index(vram_rd(a), vram_rd(a + 1), col, (attr & 'h20) != 0);
        line_pix[x] = pal_shadow[colour_on ? (attr & 7) * 4 + idx : 64 + idx];
        line_prio[x] = attr[7:0];
    endfunction

    // Object scan, selection and drawing for one line
    function automatic void draw_sprites(int ln);
        int cand [OBJECT_COUNT_TB];
        int order [OBJECT_COUNT_TB];
        bit taken [OBJECT_COUNT_TB];
        int height, n, cnt, best, bx, sy, sx, st, sa, er, a, x;
        logic [7:0] lo, hi;
        logic [1:0] idx;
        height = lcdc[2] ? 16 : 8;
        n = 0;
        for (int i = 0; i < OBJECT_COUNT_TB; i++)
        begin
            sy = oam_shadow[i * 4];
            sx = oam_shadow[i * 4 + 1];
            taken[i] = 1'b0;
            if (sy == 0 || sx == 0 || sx > 168 || sy > ln + 16 || sy + height <= ln + 16)
                continue;
            cand[n] = i;
            n++;
        end
        cnt = (n > OBJECTS_PER_LINE_TB) ? OBJECTS_PER_LINE_TB : n;
        for (int k = 0; k < cnt; k++)
        begin
            if (colour_on)
                order[k] = cand[k];
            else
            begin
                best = n;
                bx = 256;
                for (int i = 0; i < n; i++)
                    if (!taken[i] && oam_shadow[cand[i] * 4 + 1] < bx)
                    begin
                        bx = oam_shadow[cand[i] * 4 + 1];
                        best = i;
                    end
                taken[best] = 1'b1;
                order[k] = cand[best];
            end
        end
        // lowest priority first
        for (int k = cnt - 1; k >= 0; k--)
        begin
            sy = oam_shadow[order[k] * 4];
            sx = oam_shadow[order[k] * 4 + 1];
            st = oam_shadow[order[k] * 4 + 2];
            sa = oam_shadow[order[k] * 4 + 3];
            if (lcdc[2])
                st = st & 'hFE;
            er = (ln + 16 - sy) & 'hFF;
            if (sa & 'h40)
                er = (height - er - 1) & 'hFF;
            a = 16 * st + 2 * er + ((colour_on && (sa & 8)) ? BANK_BYTES : 0);
            lo = vram_rd(a);
            hi = vram_rd(a + 1);
            for (int c = 0; c < 8; c++)
            begin
                x = sx + c;
                if (x < 8 || x - 8 >= SCREEN_W)
                    continue;
                x = x - 8;
                idx = col_index(lo, hi, c, (sa & 'h20) != 0);
                if (idx == 2'd0)
                    continue;
                if (line_pix[x][0] || !(sa[7] | line_prio[x][7]))
                    line_pix[x] = pal_shadow[colour_on ? 32 + (sa & 7) * 4 + idx
                                                       : 68 + ((sa & 'h10) ? 4 : 0) + idx];
            end
        end
    endfunction

    // Expected pixel groups of one render word
    function automatic void predict_line(int ln);
        pixel_group_t g;
        int wrow;
        if (ln == 0)
        begin
            skip_count = skip_count + 8'd1;
            if (skip_count == skip_period)
                skip_count = 8'd0;
            win_row = 8'd0;
        end
        if (skip_count != 8'd0)
            return;
        if (colour_on || lcdc[0])
        begin
            for (int x = 0; x < SCREEN_W; x++)
                tile_dot(lcdc[3] ? 'h1C00 : 'h1800, (scy + ln) & 'hFF, (scx + x) & 'hFF, x);
            if (lcdc[5] && ln >= wy && wx <= 166)
            begin
                wrow = win_row;
                win_row = win_row + 8'd1;
                for (int x = 0; x < SCREEN_W; x++)
                    if (x + 7 >= wx)
                        tile_dot(lcdc[6] ? 'h1C00 : 'h1800, wrow, x + 7 - wx, x);
            end
        end
        else
        begin
            for (int x = 0; x < SCREEN_W; x++)
            begin
                line_pix[x] = BLANK_COLOUR;
                line_prio[x] = 8'd0;
            end
        end
        if (lcdc[1])
            draw_sprites(ln);
        for (int k = 0; k < SCREEN_W / 4; k++)
        begin
            g.line_no = ln[7:0];
            g.grp = k[5:0];
            for (int p = 0; p < 4; p++)
                g.px[p] = line_pix[k * 4 + p];
            g.last = (k == SCREEN_W / 4 - 1);
            pixel_groups_due.push_back(g);
        end
    endfunction

    // Send one word on the input stream and update the shadow once taken
    task automatic send_word(cmd_t cmd, int addr, int data, int ln);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {2'b00, ln[7:0], data[15:0], addr[13:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        case (cmd)
            CMD_TILE_WR: vram_shadow[addr & (TILE_BYTES - 1)] = data[7:0];
            CMD_OBJ_WR:  if (addr < OBJ_BYTES) oam_shadow[addr] = data[7:0];
            CMD_PAL_WR:  if (addr < PAL_SLOTS) pal_shadow[addr] = data[15:0];
            default:     predict_line(ln & 'hFF);
        endcase
        @(negedge clk);
    endtask

    task automatic render(int ln);
        send_word(CMD_RENDER, $urandom_range(0, 16383), $urandom_range(0, 65535), ln);
    endtask

    // Drain the pipe so a register write lands while the block is idle
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pixel_groups_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_LCD_CONTROL: lcdc = val;
            CFG_SCROLL_Y:    scy = val;
            CFG_SCROLL_X:    scx = val;
            CFG_WINDOW_Y:    wy = val;
            CFG_WINDOW_X:    wx = val;
            CFG_FRAME_SKIP:  skip_period = val;
            default:         colour_on = val[0];
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_view(logic [7:0] ctl, logic [7:0] sy, logic [7:0] sx,
                            logic [7:0] wyv, logic [7:0] wxv, logic cm);
        drain();
        write_reg(CFG_LCD_CONTROL, ctl);
        write_reg(CFG_SCROLL_Y, sy);
        write_reg(CFG_SCROLL_X, sx);
        write_reg(CFG_WINDOW_Y, wyv);
        write_reg(CFG_WINDOW_X, wxv);
        write_reg(CFG_COLOUR_MODE, {7'd0, cm});
    endtask

    // Every store entry gets written so no render reads stale contents
    task automatic test_memory_fill();
        for (int a = 0; a < TILE_BYTES; a++)
            send_word(CMD_TILE_WR, a, $urandom_range(0, 65535), $urandom_range(0, 255));
        for (int a = 0; a < OBJ_BYTES; a++)
            send_word(CMD_OBJ_WR, a, $urandom_range(0, 65535), 0);
        for (int a = 0; a < PAL_SLOTS; a++)
            send_word(CMD_PAL_WR, a, $urandom_range(0, 65535), 0);
    endtask

    // Out-of-range object and palette writes are dropped
    task automatic test_ignored_writes();
        send_word(CMD_OBJ_WR, OBJ_BYTES, 16'hFFFF, 0);
        send_word(CMD_OBJ_WR, 16383, 16'h0000, 255);
        send_word(CMD_PAL_WR, PAL_SLOTS, 16'hFFFF, 0);
        send_word(CMD_PAL_WR, 16383, 16'h5555, 0);
        render(0);
        render(143);
    endtask

    // Classic mode: background off, window edges, scroll extremes, high lines
    task automatic test_classic_view();
        set_view(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        render(0);
        set_view(8'hFF, 8'd255, 8'd255, 8'd0, 8'd7, 1'b0);
        render(0);
        render(143);
        set_view(8'hEB, 8'd17, 8'd3, 8'd143, 8'd166, 1'b0);
        render(142);
        render(143);
        set_view(8'hF3, 8'd0, 8'd0, 8'd0, 8'd167, 1'b0);
        render(200);
        render(255);
        set_view(8'hE3, 8'd90, 8'd128, 8'd10, 8'd0, 1'b0);
        render(0);
        render(9);
        render(10);
        render(11);
    endtask

    // More than ten objects on one line, x ties, tall objects, both modes
    task automatic test_object_crowd();
        for (int i = 0; i < 12; i++)
        begin
            send_word(CMD_OBJ_WR, i * 4, 16'd66, 0);
            send_word(CMD_OBJ_WR, i * 4 + 1, (i < 4) ? 20 : 180 - i * 14, 0);
            send_word(CMD_OBJ_WR, i * 4 + 3, i * 16 + 8'h0F, 0);
        end
        send_word(CMD_OBJ_WR, 12 * 4 + 1, 8'd168, 0);
        send_word(CMD_OBJ_WR, 13 * 4 + 1, 8'd169, 0);
        set_view(8'h83, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        render(50);
        render(51);
        set_view(8'h87, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        render(50);
        render(57);
        set_view(8'h66, 8'd5, 8'd200, 8'd40, 8'd60, 1'b1);
        render(0);
        render(50);
        render(57);
    endtask

    // Frame skip: long, short and wrap periods, restored with a period of one
    task automatic test_frame_skip();
        set_view(8'h93, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        write_reg(CFG_FRAME_SKIP, 8'd255);
        render(0);
        render(20);
        drain();
        write_reg(CFG_FRAME_SKIP, 8'd2);
        render(0);
        render(21);
        drain();
        write_reg(CFG_FRAME_SKIP, 8'd0);
        render(0);
        render(22);
        drain();
        write_reg(CFG_FRAME_SKIP, 8'd2);
        render(0);
        drain();
        write_reg(CFG_FRAME_SKIP, 8'd1);
        render(0);
    endtask

    // Random writes and renders over several register settings
    task automatic test_random_mix(int phases, int per_phase);
        int sel;
        for (int p = 0; p < phases; p++)
        begin
            set_view($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 150), $urandom_range(0, 175), $urandom_range(0, 1));
            write_reg(CFG_FRAME_SKIP, ($urandom_range(0, 3) == 0) ? 8'd2 : 8'd1);
            for (int i = 0; i < per_phase; i++)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 4)
                    send_word(CMD_TILE_WR, $urandom_range(0, 16383), $urandom_range(0, 65535), 0);
                else if (sel < 6)
                    send_word(CMD_OBJ_WR, $urandom_range(0, 170), $urandom_range(0, 65535), 0);
                else if (sel < 7)
                    send_word(CMD_PAL_WR, $urandom_range(0, 80), $urandom_range(0, 65535), 0);
                else if (sel < 8)
                    render(0);
                else
                    render(($urandom_range(0, 9) == 0) ? $urandom_range(144, 255)
                                                       : $urandom_range(0, 143));
            end
        end
    endtask

    // Receiver holds off while renders pile up; then the sender waits for all output
    task automatic test_backpressure();
        set_view(8'hF7, 8'd12, 8'd34, 8'd20, 8'd30, 1'b1);
        rx_hold_req = 1'b1;
        for (int i = 0; i < 8; i++)
            render(i * 3);
        drain();
    endtask

    // Receiver: random stall bursts, and one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        pixel_group_t g;
        logic [15:0] got [4];
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            for (int p = 0; p < 4; p++)
                got[p] = m_axis_tdata[14 + 16 * p +: 16];
            if (pixel_groups_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: line %0d group %0d",
                             m_axis_tdata[7:0], m_axis_tdata[13:8]);
            end
            else
            begin
                g = pixel_groups_due.pop_front();
                if (g.line_no !== m_axis_tdata[7:0] || g.grp !== m_axis_tdata[13:8]
                    || g.px[0] !== got[0] || g.px[1] !== got[1] || g.px[2] !== got[2]
                    || g.px[3] !== got[3] || g.last !== m_axis_tlast)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp line %0d grp %0d %h %h %h %h last %b | got line %0d grp %0d %h %h %h %h last %b",
                                 g.line_no, g.grp, g.px[0], g.px[1], g.px[2], g.px[3], g.last,
                                 m_axis_tdata[7:0], m_axis_tdata[13:8],
                                 got[0], got[1], got[2], got[3], m_axis_tlast);
                end
            end
        end
    end

    // Watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        stall_cycles = 0;
        rx_hold_req = 1'b0;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        lcdc = 8'd145;
        scy = 8'd0;
        scx = 8'd0;
        wy = 8'd0;
        wx = 8'd0;
        skip_period = 8'd1;
        colour_on = 1'b0;
        skip_count = 8'd0;
        win_row = 8'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_memory_fill();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        test_ignored_writes();
        test_classic_view();
        test_object_crowd();
        test_frame_skip();
        test_random_mix(5, 50);
        test_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_mix(2, 40);

        drain();
        mismatches += pixel_groups_due.size();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
